FILE: design/acfp_pkg.sv
// shared constants and types for the ascii count frame parser
package acfp_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 20;
   localparam int POS_W       = 6;
   localparam logic [POS_W-1:0] FRAME_LEN   = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] COUNT_FIRST = POS_W'(4);
   localparam logic [POS_W-1:0] SUM_FIRST   = POS_W'(8);
   localparam logic [POS_W-1:0] SUM_END     = POS_W'(16);

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 14;
   localparam int SUM_W   = 27;
   localparam int RSP_W   = 48;

   // ascii digit range
   localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
   localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

   // reset value of the start byte register
   localparam logic [BYTE_W-1:0] START_RESET = 8'h02;

   // request kinds carried on tuser
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_GAP  = 1'b1;

   // control into a decimal field accumulator
   typedef struct packed {
      logic active;
      logic stopped;
   } acc_ctrl_type;

   // outcome of a decimal field accumulator
   typedef struct packed {
      logic             stopped;
      logic [SUM_W-1:0] value;
   } acc_result_type;

endpackage

FILE: design/ascii_count_frame_parser.sv
// top level of the ascii count frame parser
// a request's result passes the input register, then the result register, which drives rsp
// throughput: one request per cycle while rsp is not stalled, set by the single input register stage
// a frame yields one response on its last byte; other requests yield none
// reset (synchronous, active high) returns to hunting and sets start byte 0x02
module ascii_count_frame_parser
   import acfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,   // start_byte
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // rx_byte[7:0]
   input  logic              req_tuser,   // func
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // note_count[13:0], total_sum[40:14], zero pad
);

   // configuration register
   logic [BYTE_W-1:0] start_byte_ff;

   // input register
   logic              st_valid_ff, st_valid_in;
   logic              st_func_ff;
   logic [BYTE_W-1:0] st_byte_ff;

   // frame state
   logic               in_frame_ff, in_frame_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               count_stop_ff, count_stop_in;
   logic               sum_stop_ff, sum_stop_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic               advance;
   logic               emit;
   logic [POS_W-1:0]   pos_next;
   acc_ctrl_type       count_ctrl, sum_ctrl;
   acc_result_type     count_res, sum_res;

   // handshake
   assign advance    = st_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !st_valid_ff || advance;
   assign st_valid_in = req_tready ? req_tvalid : st_valid_ff;

   // field accumulators
   assign count_ctrl.active  = in_frame_ff && (pos_ff >= COUNT_FIRST) && (pos_ff < SUM_FIRST);
   assign count_ctrl.stopped = count_stop_ff;
   assign sum_ctrl.active    = in_frame_ff && (pos_ff >= SUM_FIRST) && (pos_ff < SUM_END);
   assign sum_ctrl.stopped   = sum_stop_ff;

   acfp_digit_acc u_count_acc (
      .ctrl      (count_ctrl),
      .acc_value (SUM_W'(count_ff)),
      .rx_byte   (st_byte_ff),
      .result    (count_res)
   );

   acfp_digit_acc u_sum_acc (
      .ctrl      (sum_ctrl),
      .acc_value (sum_ff),
      .rx_byte   (st_byte_ff),
      .result    (sum_res)
   );

   assign pos_next = pos_ff + POS_W'(1);

   // frame state update and response load
   always_comb begin
      in_frame_in   = in_frame_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      count_stop_in = count_stop_ff;
      sum_stop_in   = sum_stop_ff;
      emit          = 1'b0;
      rsp_count_in  = rsp_count_ff;
      rsp_sum_in    = rsp_sum_ff;
      if (advance) begin
         if (st_func_ff == FUNC_GAP) begin
            in_frame_in = 1'b0;
            pos_in      = '0;
         end else if (!in_frame_ff) begin
            if (st_byte_ff == start_byte_ff) begin
               in_frame_in   = 1'b1;
               pos_in        = POS_W'(1);
               count_in      = '0;
               sum_in        = '0;
               count_stop_in = 1'b0;
               sum_stop_in   = 1'b0;
            end
         end else begin
            count_in      = count_res.value[COUNT_W-1:0];
            count_stop_in = count_res.stopped;
            sum_in        = sum_res.value;
            sum_stop_in   = sum_res.stopped;
            pos_in        = pos_next;
            if (pos_next == FRAME_LEN) begin
               in_frame_in  = 1'b0;
               pos_in       = '0;
               emit         = 1'b1;
               rsp_count_in = count_res.value[COUNT_W-1:0];
               rsp_sum_in   = sum_res.value;
            end
         end
      end
      rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_tready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_RESET;
         st_valid_ff   <= 1'b0;
         in_frame_ff   <= 1'b0;
         pos_ff        <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         count_stop_ff <= 1'b0;
         sum_stop_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            start_byte_ff <= csr_wdata;
         end
         st_valid_ff   <= st_valid_in;
         in_frame_ff   <= in_frame_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         count_stop_ff <= count_stop_in;
         sum_stop_ff   <= sum_stop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         st_func_ff <= req_tuser;
         st_byte_ff <= req_tdata;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - COUNT_W - SUM_W)'(0), rsp_sum_ff, rsp_count_ff};

   // checks
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < FRAME_LEN)
      else $error("byte position reached frame length");

   a_hunt_pos_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (pos_ff == '0))
      else $error("byte position nonzero while hunting");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_valid_ff))
      else $error("response raised without a staged request");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff && !advance) |=> st_valid_ff)
      else $error("staged request lost while stalled");

endmodule

FILE: design/acfp_digit_acc.sv
// decimal field accumulator: multiply by ten and add one ascii digit
module acfp_digit_acc
   import acfp_pkg::*;
(
   input  acc_ctrl_type       ctrl,
   input  logic [SUM_W-1:0]   acc_value,
   input  logic [BYTE_W-1:0]  rx_byte,
   output acc_result_type     result
);

   logic             is_digit;
   logic [SUM_W-1:0] digit_val;
   logic [SUM_W-1:0] times_ten;

   // digit detection and value
   assign is_digit  = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
   assign digit_val = SUM_W'(rx_byte - DIGIT_LO);
   assign times_ten = (acc_value << 3) + (acc_value << 1);

   // accumulate until the first non-digit
   always_comb begin
      result.stopped = ctrl.stopped;
      result.value   = acc_value;
      if (ctrl.active && !ctrl.stopped) begin
         if (is_digit) begin
            result.value = times_ten + digit_val;
         end else begin
            result.stopped = 1'b1;
         end
      end
   end

endmodule

FILE: tb/acfp_frame_checker.sv
// request/response checker for the ascii count frame parser: predicts frame totals and compares
module acfp_frame_checker
   import acfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   output int                mismatch_count,
   output int                totals_outstanding
);

   typedef struct packed {
      logic [COUNT_W-1:0] note_count;
      logic [SUM_W-1:0]   total_sum;
   } frame_totals_type;

   // predicted parser state
   logic [BYTE_W-1:0]  opener;
   logic               framing;
   logic [POS_W-1:0]   frame_pos;
   logic [COUNT_W-1:0] count_acc;
   logic [SUM_W-1:0]   sum_acc;
   logic               count_done;
   logic               sum_done;

   frame_totals_type expected_totals [$];

   initial begin
      mismatch_count     = 0;
      totals_outstanding = 0;
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("[%0t] acfp mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   function automatic bit is_digit(input logic [BYTE_W-1:0] b);
      return b >= DIGIT_LO && b <= DIGIT_HI;
   endfunction

   // advance the predicted parser by one accepted request
   task automatic absorb_request(input logic func, input logic [BYTE_W-1:0] b);
      frame_totals_type done;
      if (func == FUNC_GAP) begin
         framing   = 1'b0;
         frame_pos = '0;
      end else if (!framing) begin
         if (b == opener) begin
            framing    = 1'b1;
            frame_pos  = POS_W'(1);
            count_acc  = '0;
            sum_acc    = '0;
            count_done = 1'b0;
            sum_done   = 1'b0;
         end
      end else begin
         // decimal fields stop at their first non-digit
         if (frame_pos >= COUNT_FIRST && frame_pos < SUM_FIRST) begin
            if (!count_done) begin
               if (is_digit(b))
                  count_acc = COUNT_W'(count_acc * 10 + (b - DIGIT_LO));
               else
                  count_done = 1'b1;
            end
         end else if (frame_pos >= SUM_FIRST && frame_pos < SUM_END) begin
            if (!sum_done) begin
               if (is_digit(b))
                  sum_acc = SUM_W'(sum_acc * 10 + (b - DIGIT_LO));
               else
                  sum_done = 1'b1;
            end
         end
         frame_pos = frame_pos + 1'b1;
         if (frame_pos == FRAME_LEN) begin
            framing         = 1'b0;
            frame_pos       = '0;
            done.note_count = count_acc;
            done.total_sum  = sum_acc;
            expected_totals.push_back(done);
         end
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      frame_totals_type want;
      if (reset) begin
         opener     = START_RESET;
         framing    = 1'b0;
         frame_pos  = '0;
         count_acc  = '0;
         sum_acc    = '0;
         count_done = 1'b0;
         sum_done   = 1'b0;
         expected_totals.delete();
      end else begin
         if (csr_we)
            opener = csr_wdata;
         if (req_tvalid && req_tready)
            absorb_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_totals.size() == 0) begin
               report_mismatch("response with no frame outstanding", 0, rsp_tdata);
            end else begin
               want = expected_totals.pop_front();
               if (rsp_tdata[COUNT_W-1:0] !== want.note_count)
                  report_mismatch("note_count", want.note_count, rsp_tdata[COUNT_W-1:0]);
               if (rsp_tdata[COUNT_W +: SUM_W] !== want.total_sum)
                  report_mismatch("total_sum", want.total_sum, rsp_tdata[COUNT_W +: SUM_W]);
               if (rsp_tdata[RSP_W-1:COUNT_W+SUM_W] !== '0)
                  report_mismatch("padding", 0, rsp_tdata[RSP_W-1:COUNT_W+SUM_W]);
            end
         end
      end
      totals_outstanding = expected_totals.size();
   end

endmodule

FILE: tb/tb_ascii_count_frame_parser.sv
// testbench top for the ascii count frame parser: stimulus, idling and verdict
module tb_ascii_count_frame_parser
   import acfp_pkg::*;
;

   localparam int RANDOM_ITEMS = 400;
   localparam int MIN_FRAMES   = 40;
   localparam int PHASES       = 5;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [BYTE_W-1:0] csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata = '0;
   logic              req_tuser = FUNC_BYTE;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;

   logic              ready_pattern = 1'b0;
   logic              hold_off = 1'b0;
   logic              hold_go = 1'b0;

   int                mismatch_count;
   int                totals_outstanding;
   int                cycle_count = 0;
   int                burst_left = 0;
   int                frame_items = 0;
   int                frames_done = 0;
   logic [BYTE_W-1:0] start_now = START_RESET;

   assign rsp_tready = ready_pattern && !hold_off;

   ascii_count_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   acfp_frame_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .mismatch_count     (mismatch_count),
      .totals_outstanding (totals_outstanding)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_ascii_count_frame_parser: done, errors");
         $finish;
      end
   end

   // receiver stall pattern, changing mode every stretch
   always @(negedge clock) begin
      static rx_mode_type rx_mode = RX_ALWAYS;
      static int stretch_left = 0;
      if (stretch_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         stretch_left = $urandom_range(10, 80);
      end
      stretch_left--;
      case (rx_mode)
         RX_ALWAYS:   ready_pattern = 1'b1;
         RX_COIN:     ready_pattern = 1'($urandom_range(0, 1));
         RX_MOSTLY:   ready_pattern = ($urandom_range(0, 3) != 0);
         default:     ready_pattern = (stretch_left % 4 != 0);
      endcase
   end

   // one long receiver hold-off so the parser backs up into its input
   initial begin
      wait (hold_go);
      repeat ($urandom_range(10, 80)) @(negedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off = 1'b0;
   end

   // offer one request, with a random gap between bursts
   task automatic send_request(input logic func, input logic [BYTE_W-1:0] b);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tuser  = func;
      req_tdata  = b;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   // byte for a decimal field: digits up to stop_at, a non-digit there, anything after
   function automatic logic [BYTE_W-1:0] field_byte(input int idx, input int stop_at,
                                                    input bit nines);
      logic [BYTE_W-1:0] b;
      if (idx < stop_at)
         return nines ? DIGIT_HI : DIGIT_LO + BYTE_W'($urandom_range(0, 9));
      if (idx == stop_at) begin
         do b = BYTE_W'($urandom); while (b >= DIGIT_LO && b <= DIGIT_HI);
         return b;
      end
      // digits after the stop must be ignored, so offer plenty of them
      if ($urandom_range(0, 1) == 0)
         return DIGIT_LO + BYTE_W'($urandom_range(0, 9));
      return BYTE_W'($urandom);
   endfunction

   // a well-formed frame with random content, sometimes cut short by a gap
   task automatic send_frame();
      int count_stop;
      int sum_stop;
      int abort_at;
      bit nines;
      logic [BYTE_W-1:0] b;
      count_stop = ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 3);
      sum_stop   = ($urandom_range(0, 9) < 6) ? 8 : $urandom_range(0, 7);
      nines      = ($urandom_range(0, 7) == 0);
      abort_at   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, FRAME_BYTES - 1)
                                               : FRAME_BYTES;
      send_request(FUNC_BYTE, start_now);
      for (int pos = 1; pos < FRAME_BYTES; pos++) begin
         if (pos == abort_at) begin
            send_request(FUNC_GAP, BYTE_W'($urandom));
            frame_items += pos + 1;
            return;
         end
         if (pos >= COUNT_FIRST && pos < SUM_FIRST)
            b = field_byte(pos - COUNT_FIRST, count_stop, nines);
         else if (pos >= SUM_FIRST && pos < SUM_END)
            b = field_byte(pos - SUM_FIRST, sum_stop, nines);
         else
            b = BYTE_W'($urandom);
         send_request(FUNC_BYTE, b);
      end
      frame_items += FRAME_BYTES;
      frames_done++;
   endtask

   // let every outstanding frame come out, then the pipeline settle
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (totals_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // stimulus
   initial begin
      static logic [BYTE_W-1:0] directed_frame [FRAME_BYTES] = '{
         8'h02, 8'h02, 8'h00, 8'hFF, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
         8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h30, 8'hFF, 8'h00};
      static logic [BYTE_W-1:0] phase_start [PHASES] = '{8'h00, 8'hFF, 8'h35, 8'h00, 8'h02};
      phase_start[3] = BYTE_W'($urandom);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: gap and stray bytes while hunting, a frame of largest values
      // with the start byte repeated inside it, then a frame cut by a gap
      send_request(FUNC_GAP, 8'hFF);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'hFF);
      foreach (directed_frame[i])
         send_request(FUNC_BYTE, directed_frame[i]);
      send_request(FUNC_BYTE, START_RESET);
      send_request(FUNC_BYTE, 8'h31);
      send_request(FUNC_BYTE, 8'h32);
      send_request(FUNC_GAP, 8'h00);

      // random frames under several start bytes
      hold_go = 1'b1;
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         start_now = phase_start[p];
         csr_wdata = start_now;
         csr_we    = 1'b1;
         @(negedge clock);
         csr_we    = 1'b0;
         while (frame_items < (p + 1) * RANDOM_ITEMS / PHASES ||
                frames_done < (p + 1) * MIN_FRAMES / PHASES) begin
            // line noise, then a gap to get back to hunting
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3))
                  send_request(1'($urandom), BYTE_W'($urandom));
               send_request(FUNC_GAP, BYTE_W'($urandom));
            end
            send_frame();
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("tb_ascii_count_frame_parser: done, clean");
      else
         $display("tb_ascii_count_frame_parser: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
design/acfp_pkg.sv
design/acfp_digit_acc.sv
design/ascii_count_frame_parser.sv
tb/acfp_frame_checker.sv
tb/tb_ascii_count_frame_parser.sv
